[hw/rtl/mme_pkg.sv]
// shared types and constants for the matrix engine
package mme_pkg;

  localparam int MaxDimDefault = 8;
  localparam int DimW = 4;
  localparam int DataW = 16;

  typedef enum logic [3:0] {
    OP_SHAPE = 4'd0,
    OP_WR_A  = 4'd1,
    OP_WR_B  = 4'd2,
    OP_RD_A  = 4'd3,
    OP_MUL   = 4'd4,
    OP_ADD   = 4'd5,
    OP_SUB   = 4'd6,
    OP_ELEM  = 4'd7,
    OP_SCALE = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SHAPE = 2'd1,
    ST_INDEX = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  localparam logic [DimW-1:0] CfgBRows = 4'd0;
  localparam logic [DimW-1:0] CfgBCols = 4'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MAC,
    S_WB,
    S_COPY,
    S_EW,
    S_EW_WB,
    S_DONE
  } state_t;

  // alu operation selector
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  // floor shift by 8 when sh is set, then saturate a wide value to 16 bits
  function automatic logic [DataW:0] sat_shift(input logic signed [39:0] v, input logic sh);
    logic signed [39:0] s;
    logic [DataW:0] r;
    begin
      s = sh ? (v >>> 8) : v;
      if (s > 40'sd32767) r = {1'b1, 16'h7fff};
      else if (s < -40'sd32768) r = {1'b1, 16'h8000};
      else r = {1'b0, s[DataW-1:0]};
      return r;
    end
  endfunction

endpackage

[hw/rtl/matrix_multiply_elementwise_engine.sv]
// top level of the matrix engine: stores, sequencer and result register
// Usage: an item (opcode,row,col,value) is transferred when in_valid is high
// and in_stall is low. Each item yields one result (read_value,status) on
// the out channel, held in a register until transferred.
// Elementwise ops visit each element of A in turn. Multiply takes one
// MAC step per product term plus a priming step and a write-back per
// output element, then a copy pass from scratch back into A. All
// arithmetic goes through a single shared multiply-accumulate unit.
// in_stall is high while an item is at work or its result waits.
// Configuration (b_rows, b_cols) must be written by cfg_we, cfg_index,
// cfg_data only while idle; the block itself does not enforce this.
// A receiver stall only holds the result register.
// Reset (rst_n low, synchronous) sets A to min(MAX_DIM, 8) square, B shape
// to 8x8; the stores are undefined until written. No clearing pass is needed.
module matrix_multiply_elementwise_engine #(
  parameter int MAX_DIM = mme_pkg::MaxDimDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_read_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  localparam int Cells = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(Cells) > 0 ? $clog2(Cells) : 1;
  localparam logic [4:0] MaxD = 5'(MAX_DIM);
  localparam logic [3:0] RstD = (MAX_DIM < 8) ? 4'(MAX_DIM) : 4'd8;

  logic [15:0] mem_a [Cells];
  logic [15:0] mem_b [Cells];
  logic [15:0] mem_s [Cells];

  mme_pkg::state_t state_r, state_nxt;
  logic [3:0] b_rows_r, b_cols_r, a_rows_r, a_cols_r;
  logic [3:0] op_r, row_r, col_r;
  logic [15:0] val_r;
  logic [3:0] i_r, j_r, k_r;
  logic [AW-1:0] idx_r;
  logic sat_r;
  logic out_valid_r;
  logic [15:0] out_rd_r;
  logic [1:0] out_st_r;

  logic [15:0] ra_r, rb_r;
  logic [AW-1:0] ra_addr, rb_addr, rs_addr;
  logic clr, acc_en;
  mme_pkg::alu_op_t alu_op;
  logic [16:0] res;
  logic signed [15:0] ax, ay;

  function automatic logic dim_ok(input logic [3:0] d);
    return (d != 4'd0) && ({1'b0, d} <= MaxD);
  endfunction

  logic b_ok, same, take;
  logic [AW-1:0] n_cells;
  assign b_ok = dim_ok(b_rows_r) && dim_ok(b_cols_r);
  assign same = b_ok && a_rows_r == b_rows_r && a_cols_r == b_cols_r;
  assign n_cells = AW'(a_rows_r * a_cols_r - 8'd1);
  assign in_stall = (state_r != mme_pkg::S_IDLE) || out_valid_r;
  assign take = in_valid && !in_stall;

  // mac address: A[i][k], B[k][j]; single access: A[row][col]; elementwise: idx
  always_comb begin
    if (state_r == mme_pkg::S_MAC || state_r == mme_pkg::S_IDLE ||
        state_r == mme_pkg::S_WB) begin
      ra_addr = AW'(i_r * a_cols_r + k_r);
      rb_addr = AW'(k_r * b_cols_r + j_r);
    end else if (state_r == mme_pkg::S_RD) begin
      ra_addr = AW'(row_r * a_cols_r + col_r);
      rb_addr = idx_r;
    end else begin
      ra_addr = idx_r;
      rb_addr = idx_r;
    end
  end

  // copy pass reads one entry ahead of the entry being written
  assign rs_addr = (k_r != 4'd0) ? idx_r + 1'b1 : idx_r;

  always_ff @(posedge clk) begin
    ra_r <= mem_a[ra_addr];
    rb_r <= (state_r == mme_pkg::S_COPY) ? mem_s[rs_addr] : mem_b[rb_addr];
  end

  always_comb begin
    case (op_r)
      mme_pkg::OP_ADD: alu_op = mme_pkg::ALU_ADD;
      mme_pkg::OP_SUB: alu_op = mme_pkg::ALU_SUB;
      default:         alu_op = mme_pkg::ALU_MUL;
    endcase
    ax = ra_r;
    ay = (op_r == mme_pkg::OP_SCALE) ? val_r : rb_r;
  end

  mme_alu u_alu (
    .clk(clk), .clr(clr), .acc_en(acc_en), .op(alu_op),
    .x(ax), .y(ay), .res(res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mme_pkg::S_IDLE: if (take) state_nxt = mme_pkg::S_RD;
      mme_pkg::S_RD: begin
        case (op_r)
          mme_pkg::OP_MUL:
            state_nxt = (!b_ok || a_cols_r != b_rows_r) ? mme_pkg::S_DONE : mme_pkg::S_MAC;
          mme_pkg::OP_ADD, mme_pkg::OP_SUB, mme_pkg::OP_ELEM:
            state_nxt = same ? mme_pkg::S_EW : mme_pkg::S_DONE;
          mme_pkg::OP_SCALE: state_nxt = mme_pkg::S_EW;
          default: state_nxt = mme_pkg::S_DONE;
        endcase
      end
      mme_pkg::S_MAC: if (k_r == a_cols_r) state_nxt = mme_pkg::S_WB;
      mme_pkg::S_WB:
        if (i_r == a_rows_r - 4'd1 && j_r == b_cols_r - 4'd1) state_nxt = mme_pkg::S_COPY;
        else state_nxt = mme_pkg::S_MAC;
      mme_pkg::S_COPY:
        if (k_r != 4'd0 && idx_r == AW'(a_rows_r * b_cols_r - 8'd1)) state_nxt = mme_pkg::S_DONE;
      mme_pkg::S_EW: if (k_r == 4'd1) state_nxt = mme_pkg::S_EW_WB;
      mme_pkg::S_EW_WB: state_nxt = (idx_r == n_cells) ? mme_pkg::S_DONE : mme_pkg::S_EW;
      mme_pkg::S_DONE: state_nxt = mme_pkg::S_IDLE;
      default: state_nxt = mme_pkg::S_IDLE;
    endcase
  end

  // alu control
  always_comb begin
    clr = 1'b0;
    acc_en = 1'b0;
    case (state_r)
      mme_pkg::S_MAC: begin
        acc_en = (k_r != 4'd0);
        clr = (k_r == 4'd1);
      end
      mme_pkg::S_EW: begin
        acc_en = (k_r == 4'd1);
        clr = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::S_IDLE;
      b_rows_r <= 4'd8;
      b_cols_r <= 4'd8;
      a_rows_r <= RstD;
      a_cols_r <= RstD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == mme_pkg::CfgBRows) b_rows_r <= cfg_data;
      if (cfg_we && cfg_index == mme_pkg::CfgBCols) b_cols_r <= cfg_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == mme_pkg::S_DONE) out_valid_r <= 1'b1;
      if (state_r == mme_pkg::S_RD && op_r == mme_pkg::OP_SHAPE &&
          dim_ok(row_r) && dim_ok(col_r)) begin
        a_rows_r <= row_r;
        a_cols_r <= col_r;
      end
      if (state_r == mme_pkg::S_WB && state_nxt == mme_pkg::S_COPY) a_cols_r <= b_cols_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mme_pkg::S_IDLE: if (take) begin
        op_r <= in_opcode;
        row_r <= in_row;
        col_r <= in_col;
        val_r <= in_value;
        i_r <= 4'd0;
        j_r <= 4'd0;
        k_r <= 4'd0;
        idx_r <= '0;
        sat_r <= 1'b0;
        out_rd_r <= '0;
        out_st_r <= mme_pkg::ST_OK;
      end
      mme_pkg::S_RD: begin
        case (op_r)
          mme_pkg::OP_SHAPE:
            if (!(dim_ok(row_r) && dim_ok(col_r))) out_st_r <= mme_pkg::ST_INDEX;
          mme_pkg::OP_WR_A:
            if (row_r < a_rows_r && col_r < a_cols_r) mem_a[ra_addr] <= val_r;
            else out_st_r <= mme_pkg::ST_INDEX;
          mme_pkg::OP_WR_B:
            if (!b_ok) out_st_r <= mme_pkg::ST_SHAPE;
            else if (row_r < b_rows_r && col_r < b_cols_r)
              mem_b[AW'(row_r * b_cols_r + col_r)] <= val_r;
            else out_st_r <= mme_pkg::ST_INDEX;
          mme_pkg::OP_RD_A:
            if (!(row_r < a_rows_r && col_r < a_cols_r)) out_st_r <= mme_pkg::ST_INDEX;
          mme_pkg::OP_MUL:
            if (!b_ok || a_cols_r != b_rows_r) out_st_r <= mme_pkg::ST_SHAPE;
          mme_pkg::OP_ADD, mme_pkg::OP_SUB, mme_pkg::OP_ELEM:
            if (!same) out_st_r <= mme_pkg::ST_SHAPE;
          default: ;
        endcase
      end
      mme_pkg::S_MAC: k_r <= k_r + 4'd1;
      mme_pkg::S_WB: begin
        mem_s[AW'(i_r * b_cols_r + j_r)] <= res[15:0];
        if (res[16]) sat_r <= 1'b1;
        k_r <= 4'd0;
        if (j_r == b_cols_r - 4'd1) begin
          j_r <= 4'd0;
          i_r <= i_r + 4'd1;
        end else begin
          j_r <= j_r + 4'd1;
        end
      end
      mme_pkg::S_COPY: begin
        // k_r marks the first cycle, where scratch read is not yet valid
        if (k_r == 4'd0) begin
          k_r <= 4'd1;
        end else begin
          mem_a[idx_r] <= rb_r;
          idx_r <= idx_r + 1'b1;
          if (state_nxt == mme_pkg::S_DONE && sat_r) out_st_r <= mme_pkg::ST_SAT;
        end
      end
      mme_pkg::S_EW: k_r <= k_r + 4'd1;
      mme_pkg::S_EW_WB: begin
        mem_a[idx_r] <= res[15:0];
        k_r <= 4'd0;
        idx_r <= idx_r + 1'b1;
        if (res[16] || sat_r) out_st_r <= mme_pkg::ST_SAT;
        if (res[16]) sat_r <= 1'b1;
      end
      mme_pkg::S_DONE:
        if (op_r == mme_pkg::OP_RD_A && out_st_r == mme_pkg::ST_OK) out_rd_r <= ra_r;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status = out_st_r;
endmodule

[hw/rtl/mme_alu.sv]
// shared multiply-accumulate / add / subtract unit with saturation
module mme_alu (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        acc_en,
  input  mme_pkg::alu_op_t            op,
  input  logic signed [15:0]          x,
  input  logic signed [15:0]          y,
  output logic [16:0]                 res
);
  logic signed [39:0] acc_r;
  logic signed [39:0] acc_nxt;
  logic signed [39:0] term;

  always_comb begin
    case (op)
      mme_pkg::ALU_ADD: term = 40'(x) + 40'(y);
      mme_pkg::ALU_SUB: term = 40'(x) - 40'(y);
      default:          term = 40'(x * y);
    endcase
    acc_nxt = clr ? term : acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (acc_en) acc_r <= acc_nxt;
  end

  assign res = mme_pkg::sat_shift(acc_r, op == mme_pkg::ALU_MUL);
endmodule

[hw/rtl/mme_checker.sv]
// port-level checks for the matrix engine
module mme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_read_value,
  input logic [1:0]  out_status
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("took item while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_status)) else $error("result lost");
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open with pending result");
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mme_pkg::ST_OK) |-> out_read_value == 16'd0)
    else $error("read value on error");
endmodule

bind matrix_multiply_elementwise_engine mme_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_read_value(out_read_value), .out_status(out_status)
);

[verif/matrix_multiply_elementwise_engine_tb.sv]
// testbench for the matrix engine: directed table, random commands, self-checking predictor
module matrix_multiply_elementwise_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cells = 64;
  localparam int ItemsPerPhase = 112;
  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 800;

  typedef struct {
    logic [3:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] val;
    bit                 typed;
    logic signed [15:0] rd;
    mme_pkg::status_t   st;
  } cmd_row_t;

  typedef struct {
    logic signed [15:0] rd;
    mme_pkg::status_t   st;
  } engine_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_opcode = '0;
  logic [3:0] in_row = '0;
  logic [3:0] in_col = '0;
  logic signed [15:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_read_value;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  // predictor state
  logic signed [15:0] mat_a [Cells];
  logic signed [15:0] mat_b [Cells];
  logic signed [15:0] scratch [Cells];
  int a_rows, a_cols, b_rows, b_cols;

  engine_result_t pending_results[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int stall_burst = 0;
  int cycle_cnt = 0;

  cmd_row_t reset_checks[] = '{
    '{mme_pkg::OP_SHAPE, 4'd0, 4'd0, 16'sd0, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{mme_pkg::OP_SHAPE, 4'd9, 4'd9, 16'sd0, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{mme_pkg::OP_SHAPE, 4'd15, 4'd15, -16'sd1, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{mme_pkg::OP_SHAPE, 4'd3, 4'd0, 16'sd0, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{mme_pkg::OP_WR_A, 4'd8, 4'd0, 16'sd5, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{mme_pkg::OP_WR_B, 4'd0, 4'd8, 16'sd5, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{mme_pkg::OP_RD_A, 4'd15, 4'd15, 16'sd0, 1'b1, 16'sd0, mme_pkg::ST_INDEX},
    '{4'd9, 4'd0, 4'd0, 16'sd0, 1'b1, 16'sd0, mme_pkg::ST_OK},
    '{4'd15, 4'd15, 4'd15, -16'sd1, 1'b1, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SHAPE, 4'd8, 4'd8, 16'sd0, 1'b1, 16'sd0, mme_pkg::ST_OK}
  };

  cmd_row_t extreme_cmds[] = '{
    '{mme_pkg::OP_WR_A, 4'd0, 4'd0, 16'sh7fff, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_WR_B, 4'd0, 4'd0, 16'sh7fff, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_WR_A, 4'd7, 4'd7, -16'sh8000, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_WR_B, 4'd7, 4'd7, -16'sh8000, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_RD_A, 4'd7, 4'd7, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_ADD, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_RD_A, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SUB, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_ELEM, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SCALE, 4'd0, 4'd0, -16'sh8000, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SCALE, 4'd0, 4'd0, 16'sd256, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SCALE, 4'd0, 4'd0, 16'sd3, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_MUL, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_RD_A, 4'd3, 4'd4, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SHAPE, 4'd1, 4'd8, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_MUL, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_ADD, 4'd0, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_RD_A, 4'd0, 4'd7, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_RD_A, 4'd1, 4'd0, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK},
    '{mme_pkg::OP_SHAPE, 4'd8, 4'd8, 16'sd0, 1'b0, 16'sd0, mme_pkg::ST_OK}
  };

  int phase_rows[] = '{8, 1, 8, 1, 0, 15, 4, 3, 2};
  int phase_cols[] = '{8, 1, 1, 8, 8, 15, 5, 3, 7};

  matrix_multiply_elementwise_engine DUT (.*);

  always #2 clk = ~clk;

  function automatic logic signed [15:0] clamp16(input longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic bit dim_ok(input int d);
    return d >= 1 && d <= 8;
  endfunction

  task automatic compute_result(input logic [3:0] op, input logic [3:0] row,
                                input logic [3:0] col, input logic signed [15:0] val,
                                output engine_result_t res);
    bit sat;
    bit b_ok;
    bit same;
    int n;
    longint acc;
    longint x;
    longint y;
    sat = 1'b0;
    b_ok = dim_ok(b_rows) && dim_ok(b_cols);
    same = b_ok && a_rows == b_rows && a_cols == b_cols;
    n = a_rows * a_cols;
    res.rd = '0;
    res.st = mme_pkg::ST_OK;
    case (op)
      mme_pkg::OP_SHAPE: begin
        if (dim_ok(row) && dim_ok(col)) begin
          a_rows = row;
          a_cols = col;
        end else res.st = mme_pkg::ST_INDEX;
      end
      mme_pkg::OP_WR_A: begin
        if (row < a_rows && col < a_cols) mat_a[row * a_cols + col] = val;
        else res.st = mme_pkg::ST_INDEX;
      end
      mme_pkg::OP_WR_B: begin
        if (!b_ok) res.st = mme_pkg::ST_SHAPE;
        else if (row < b_rows && col < b_cols) mat_b[row * b_cols + col] = val;
        else res.st = mme_pkg::ST_INDEX;
      end
      mme_pkg::OP_RD_A: begin
        if (row < a_rows && col < a_cols) res.rd = mat_a[row * a_cols + col];
        else res.st = mme_pkg::ST_INDEX;
      end
      mme_pkg::OP_MUL: begin
        if (!b_ok || a_cols != b_rows) res.st = mme_pkg::ST_SHAPE;
        else begin
          for (int r = 0; r < a_rows; r++)
            for (int c = 0; c < b_cols; c++) begin
              acc = 0;
              for (int s = 0; s < a_cols; s++)
                acc += longint'(mat_a[r * a_cols + s]) * longint'(mat_b[s * b_cols + c]);
              scratch[r * b_cols + c] = clamp16(acc >>> 8, sat);
            end
          a_cols = b_cols;
          for (int i = 0; i < a_rows * a_cols; i++) mat_a[i] = scratch[i];
        end
      end
      mme_pkg::OP_ADD, mme_pkg::OP_SUB, mme_pkg::OP_ELEM: begin
        if (!same) res.st = mme_pkg::ST_SHAPE;
        else begin
          for (int i = 0; i < n; i++) begin
            x = mat_a[i];
            y = mat_b[i];
            if (op == mme_pkg::OP_ADD) mat_a[i] = clamp16(x + y, sat);
            else if (op == mme_pkg::OP_SUB) mat_a[i] = clamp16(x - y, sat);
            else mat_a[i] = clamp16((x * y) >>> 8, sat);
          end
        end
      end
      mme_pkg::OP_SCALE: begin
        for (int i = 0; i < n; i++)
          mat_a[i] = clamp16((longint'(mat_a[i]) * longint'(val)) >>> 8, sat);
      end
      default: ;
    endcase
    if (sat) res.st = mme_pkg::ST_SAT;
  endtask

  // drive one command and hold it until the transfer
  task automatic send_cmd(input logic [3:0] op, input logic [3:0] row, input logic [3:0] col,
                          input logic signed [15:0] val, input bit typed,
                          input engine_result_t typed_res);
    engine_result_t res;
    in_valid = 1'b1;
    in_opcode = op;
    in_row = row;
    in_col = col;
    in_value = val;
    do @(posedge clk); while (in_stall);
    compute_result(op, row, col, val, res);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_cfg(input logic [3:0] idx, input int data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data[3:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == mme_pkg::CfgBRows) b_rows = data;
    else b_cols = data;
  endtask

  function automatic logic signed [15:0] rand_data();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 1023) - 512);
    return 16'($urandom());
  endfunction

  task automatic random_cmd();
    int k;
    logic [3:0] op;
    logic [3:0] row;
    logic [3:0] col;
    logic signed [15:0] val;
    engine_result_t none;
    k = $urandom_range(0, 99);
    row = 4'($urandom_range(0, 15));
    col = 4'($urandom_range(0, 15));
    val = rand_data();
    none = '{16'sd0, mme_pkg::ST_OK};
    if (k < 30) begin
      op = mme_pkg::OP_WR_A;
      if ($urandom_range(0, 9) != 0) begin
        row = 4'($urandom_range(0, a_rows - 1));
        col = 4'($urandom_range(0, a_cols - 1));
      end
    end else if (k < 50) begin
      op = mme_pkg::OP_WR_B;
      if ($urandom_range(0, 9) != 0 && dim_ok(b_rows) && dim_ok(b_cols)) begin
        row = 4'($urandom_range(0, b_rows - 1));
        col = 4'($urandom_range(0, b_cols - 1));
      end
    end else if (k < 70) begin
      op = mme_pkg::OP_RD_A;
      if ($urandom_range(0, 9) != 0) begin
        row = 4'($urandom_range(0, a_rows - 1));
        col = 4'($urandom_range(0, a_cols - 1));
      end
    end else if (k < 75) begin
      op = mme_pkg::OP_SHAPE;
      case ($urandom_range(0, 3))
        0, 1: begin
          row = 4'(b_rows);
          col = 4'(b_cols);
        end
        2: begin
          row = 4'($urandom_range(1, 8));
          col = 4'(b_rows);
        end
        default: ;
      endcase
    end else if (k < 79) op = mme_pkg::OP_MUL;
    else if (k < 83) op = mme_pkg::OP_ADD;
    else if (k < 86) op = mme_pkg::OP_SUB;
    else if (k < 89) op = mme_pkg::OP_ELEM;
    else if (k < 93) begin
      op = mme_pkg::OP_SCALE;
      val = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 767) - 256);
    end else if (k < 96) op = 4'($urandom_range(9, 15));
    else op = 4'($urandom_range(0, 15));
    send_cmd(op, row, col, val, 1'b0, none);
  endtask

  // receiver side stall bursts and the long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
      out_stall = 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_burst = $urandom_range(0, 14);
      out_stall = 1'b1;
    end else out_stall = 1'b0;
  end

  always @(posedge clk) begin
    engine_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: read_value %0d status %0d",
               out_read_value, out_status);
        failed = 1'b1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_read_value !== exp_res.rd) begin
          $error("read_value expected %0d actual %0d", exp_res.rd, out_read_value);
          failed = 1'b1;
        end
        if (out_status !== exp_res.st) begin
          $error("status expected %0d actual %0d", exp_res.st, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    engine_result_t typed_res;
    for (int i = 0; i < Cells; i++) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
      scratch[i] = '0;
    end
    a_rows = 8;
    a_cols = 8;
    b_rows = 8;
    b_cols = 8;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (reset_checks[i]) begin
      typed_res = '{reset_checks[i].rd, reset_checks[i].st};
      send_cmd(reset_checks[i].op, reset_checks[i].row, reset_checks[i].col,
               reset_checks[i].val, 1'b1, typed_res);
    end
    // fill both stores so no later command touches an unwritten entry
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        send_cmd(mme_pkg::OP_WR_A, 4'(r), 4'(c), rand_data(), 1'b0, typed_res);
        send_cmd(mme_pkg::OP_WR_B, 4'(r), 4'(c), rand_data(), 1'b0, typed_res);
      end
    foreach (extreme_cmds[i])
      send_cmd(extreme_cmds[i].op, extreme_cmds[i].row, extreme_cmds[i].col,
               extreme_cmds[i].val, 1'b0, typed_res);

    foreach (phase_rows[p]) begin
      wait (pending_results.size() == 0);
      repeat (SettleCycles) @(posedge clk);
      @(negedge clk);
      write_cfg(mme_pkg::CfgBRows, phase_rows[p]);
      write_cfg(mme_pkg::CfgBCols, phase_cols[p]);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == phase_rows.size() - 1 && n >= ItemsPerPhase - 60) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 15)) @(negedge clk);
        random_cmd();
      end
    end

    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
